### sv/bpcm_pkg.sv
// shared types and constants for the byte pair correlation block
// no dependencies
`default_nettype none

package bpcm_pkg;

    localparam int MAX_SAMPLES = 65536;

    // accumulator widths follow from the sample bound
    localparam int N_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = N_W + 8;
    localparam int SQ_W   = N_W + 16;
    localparam int VAR_W  = N_W + SQ_W;
    localparam int BIG_W  = 2 * VAR_W + 34;
    localparam int MAG_W  = 17;
    localparam int BIT_W  = 5;
    localparam int PC_W   = 17;
    localparam int STAT_W = 2;

    localparam logic [MAG_W-1:0] Q_ONE = MAG_W'(65536);

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERRUN = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_POST,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NSAB,
        OP_SASB,
        OP_NSAA,
        OP_SASA,
        OP_NSBB,
        OP_SBSB,
        OP_VV,
        OP_NN,
        OP_TT,
        OP_TV
    } t_op;

endpackage

`default_nettype wire

### sv/bpcm_if.sv
// request and result channel interfaces
// depends on bpcm_pkg
`default_nettype none

interface bpcm_in_if import bpcm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic       last;
    modport source (output valid, sample_a, sample_b, last, input ready);
    modport sink   (input valid, sample_a, sample_b, last, output ready);
endinterface

interface bpcm_out_if import bpcm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MAG_W-1:0]  magnitude;
    logic [STAT_W-1:0] status;
    logic [PC_W-1:0]   pair_count;
    modport source (output valid, magnitude, status, pair_count, input ready);
    modport sink   (input valid, magnitude, status, pair_count, output ready);
endinterface

`default_nettype wire

### sv/byte_pair_correlation_magnitude.sv
// absolute pearson correlation of byte pairs, one shift-add multiplier under a sequencer
// depends on bpcm_pkg and the channel interfaces in bpcm_if
// a plain pair is taken while idle; a last pair starts the product sequence on the
// bit-serial multiplier (one multiplier bit per cycle, 10 product kinds)
// throughput: one pair per cycle until a last pair, then not ready until the result is queued
// reset: synchronous active low, clears sums, count, sequencer and output valid
`default_nettype none

module byte_pair_correlation_magnitude import bpcm_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bpcm_in_if.sink     i_in,
    bpcm_out_if.source  o_out
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // running sums
    logic [N_W-1:0]   r_n, n_n;
    logic [SUM_W-1:0] r_sa, n_sa, r_sb, n_sb;
    logic [SQ_W-1:0]  r_sab, n_sab, r_saa, n_saa, r_sbb, n_sbb;
    logic             r_ovf, n_ovf;

    // shared shift-add multiplier
    logic [BIG_W-1:0] r_x, n_x, r_y, n_y, r_acc, n_acc;

    // intermediate results
    logic [BIG_W-1:0] r_tmp, n_tmp, r_num, n_num, r_va, n_va, r_vb, n_vb;
    logic [BIG_W-1:0] r_vv, n_vv, r_rhs, n_rhs;
    logic             r_zero, n_zero;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [BIT_W-1:0] r_bit, n_bit;

    // output register
    logic              r_ovalid, n_ovalid;
    logic [MAG_W-1:0]  r_omag, n_omag;
    logic [STAT_W-1:0] r_ostat, n_ostat;
    logic [PC_W-1:0]   r_ocnt, n_ocnt;

    logic             w_in_acc, w_out_free, w_ge, w_le;
    logic [BIG_W-1:0] w_absd;
    logic [MAG_W-1:0] w_trial;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_ge       = r_tmp >= r_acc;
    assign w_absd     = w_ge ? (r_tmp - r_acc) : (r_acc - r_tmp);
    assign w_le       = r_acc <= r_rhs;
    // candidate magnitude with the current bit set
    assign w_trial    = r_mag | (MAG_W'(1) << r_bit);

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.magnitude  = r_omag;
    assign o_out.status     = r_ostat;
    assign o_out.pair_count = r_ocnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in.last) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_MUL;
            S_MUL: begin
                if (r_y == '0) n_state = S_POST;
            end
            S_POST: begin
                case (r_op)
                    OP_SBSB: begin
                        if (r_va == '0 || w_absd == '0) n_state = S_DONE;
                        else n_state = S_LOAD;
                    end
                    OP_TV: begin
                        if (r_bit == '0 || (w_le && w_trial == Q_ONE)) n_state = S_DONE;
                        else n_state = S_LOAD;
                    end
                    default: n_state = S_LOAD;
                endcase
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op = r_op;
        n_n = r_n; n_sa = r_sa; n_sb = r_sb;
        n_sab = r_sab; n_saa = r_saa; n_sbb = r_sbb; n_ovf = r_ovf;
        n_x = r_x; n_y = r_y; n_acc = r_acc;
        n_tmp = r_tmp; n_num = r_num; n_va = r_va; n_vb = r_vb;
        n_vv = r_vv; n_rhs = r_rhs; n_zero = r_zero;
        n_mag = r_mag; n_bit = r_bit;
        n_ovalid = r_ovalid; n_omag = r_omag; n_ostat = r_ostat; n_ocnt = r_ocnt;

        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    // pairs past the bound are dropped and flagged
                    if (r_n < N_W'(MAX_SAMPLES)) begin
                        n_n   = r_n + N_W'(1);
                        n_sa  = r_sa + SUM_W'(i_in.sample_a);
                        n_sb  = r_sb + SUM_W'(i_in.sample_b);
                        n_sab = r_sab + SQ_W'(i_in.sample_a) * SQ_W'(i_in.sample_b);
                        n_saa = r_saa + SQ_W'(i_in.sample_a) * SQ_W'(i_in.sample_a);
                        n_sbb = r_sbb + SQ_W'(i_in.sample_b) * SQ_W'(i_in.sample_b);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_op   = OP_NSAB;
                    n_zero = 1'b0;
                end
            end
            S_LOAD: begin
                n_acc = '0;
                case (r_op)
                    OP_NSAB: begin n_x = BIG_W'(r_sab); n_y = BIG_W'(r_n);  end
                    OP_SASB: begin n_x = BIG_W'(r_sa);  n_y = BIG_W'(r_sb); end
                    OP_NSAA: begin n_x = BIG_W'(r_saa); n_y = BIG_W'(r_n);  end
                    OP_SASA: begin n_x = BIG_W'(r_sa);  n_y = BIG_W'(r_sa); end
                    OP_NSBB: begin n_x = BIG_W'(r_sbb); n_y = BIG_W'(r_n);  end
                    OP_SBSB: begin n_x = BIG_W'(r_sb);  n_y = BIG_W'(r_sb); end
                    OP_VV:   begin n_x = r_va;  n_y = r_vb;  end
                    OP_NN:   begin n_x = r_num; n_y = r_num; end
                    OP_TT:   begin n_x = BIG_W'(w_trial); n_y = BIG_W'(w_trial); end
                    OP_TV:   begin n_x = r_vv;  n_y = r_tmp; end
                    default: begin n_x = '0; n_y = '0; end
                endcase
            end
            S_MUL: begin
                if (r_y != '0) begin
                    if (r_y[0]) n_acc = r_acc + r_x;
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
            end
            S_POST: begin
                case (r_op)
                    OP_NSAB: begin n_tmp = r_acc; n_op = OP_SASB; end
                    OP_SASB: begin n_num = w_absd; n_op = OP_NSAA; end
                    OP_NSAA: begin n_tmp = r_acc; n_op = OP_SASA; end
                    OP_SASA: begin n_va = w_absd; n_op = OP_NSBB; end
                    OP_NSBB: begin n_tmp = r_acc; n_op = OP_SBSB; end
                    OP_SBSB: begin
                        n_vb   = w_absd;
                        n_zero = (r_va == '0) || (w_absd == '0);
                        n_mag  = '0;
                        n_op   = OP_VV;
                    end
                    OP_VV: begin n_vv = r_acc; n_op = OP_NN; end
                    OP_NN: begin
                        n_rhs = r_acc << 32;
                        n_bit = BIT_W'(16);
                        n_op  = OP_TT;
                    end
                    OP_TT: begin n_tmp = r_acc; n_op = OP_TV; end
                    OP_TV: begin
                        if (w_le) n_mag = w_trial;
                        n_bit = r_bit - BIT_W'(1);
                        n_op  = OP_TT;
                    end
                    default: n_op = OP_NSAB;
                endcase
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_omag   = r_zero ? '0 : r_mag;
                    n_ostat  = r_ovf ? STAT_OVERRUN : (r_zero ? STAT_ZERO : STAT_OK);
                    n_ocnt   = PC_W'(r_n);
                    n_n = '0; n_sa = '0; n_sb = '0;
                    n_sab = '0; n_saa = '0; n_sbb = '0; n_ovf = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_NSAB;
            r_n      <= '0;
            r_sa     <= '0;
            r_sb     <= '0;
            r_sab    <= '0;
            r_saa    <= '0;
            r_sbb    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_zero   <= 1'b0;
            r_bit    <= '0;
            r_mag    <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_n      <= n_n;
            r_sa     <= n_sa;
            r_sb     <= n_sb;
            r_sab    <= n_sab;
            r_saa    <= n_saa;
            r_sbb    <= n_sbb;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            r_zero   <= n_zero;
            r_bit    <= n_bit;
            r_mag    <= n_mag;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_tmp  <= n_tmp;
        r_num  <= n_num;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_vv   <= n_vv;
        r_rhs  <= n_rhs;
        r_omag <= n_omag;
        r_ostat <= n_ostat;
        r_ocnt <= n_ocnt;
    end

    // a last pair always starts the sequencer
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.last |=> r_state == S_LOAD)
        else $error("last pair did not start computation");

    // zero variance result carries zero magnitude
    a_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ostat == STAT_ZERO |-> r_omag == '0)
        else $error("zero variance with nonzero magnitude");

    // magnitude never exceeds one
    a_mag_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_omag <= Q_ONE)
        else $error("magnitude above one");

endmodule

`default_nettype wire
